// ----- design/ils_pkg.sv -----
// Shared types and codes of the indexed list store.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FIDX_W = 6;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_PUSH   = 3'd3,
    OP_POP    = 3'd4,
    OP_FIND   = 3'd5,
    OP_REMOVE = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [FIDX_W-1:0] found_index;
    logic [FILL_W-1:0] fill_count;
    logic              empty_res;
    status_e           status;
  } res_t;

endpackage

`default_nettype wire

// ----- design/ils_engine.sv -----
// List memory, fill count and the sequencer that walks it one entry at a time.
`timescale 1ns / 1ps
`default_nettype none

module ils_engine import ils_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  input  wire logic take_i,
  output logic      idle_o,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RD_ISSUE = 10'b0000000010,
    S_RD_WAIT  = 10'b0000000100,
    S_UP_RD    = 10'b0000001000,
    S_UP_WR    = 10'b0000010000,
    S_DN_RD    = 10'b0000100000,
    S_DN_WR    = 10'b0001000000,
    S_SC_RD    = 10'b0010000000,
    S_SC_CMP   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           tgt_q, tgt_d;
  logic [DATA_WIDTH-1:0]   val_q, val_d;
  logic                    rem_q, rem_d;
  logic [WORD_W-1:0]       rd_q, rd_d;
  logic [FIDX_W-1:0]       fidx_q, fidx_d;
  status_e                 status_q, status_d;

  logic [DATA_WIDTH-1:0]   mem [DEPTH];
  logic [DATA_WIDTH-1:0]   rd_data_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;

  logic                    step_down;
  logic [CW-1:0]           idx_step;
  logic [CMPW-1:0]         pos_x;
  logic [CMPW-1:0]         cnt_x;
  logic                    list_empty;
  logic                    list_full;

  // One incrementer serves every walk: it counts down while opening a gap and up otherwise.
  assign step_down = (state_q == S_UP_RD) || (state_q == S_UP_WR);
  assign idx_step  = idx_q + (step_down ? {CW{1'b1}} : CW'(1));

  assign pos_x      = CMPW'(req_i.position);
  assign cnt_x      = CMPW'(count_q);
  assign list_empty = (count_q == '0);
  assign list_full  = (count_q == CW'(DEPTH));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    val_d     = val_q;
    rem_d     = rem_q;
    rd_d      = rd_q;
    fidx_d    = fidx_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_raddr = idx_q[AW-1:0];
    mem_wdata = rd_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rd_d     = '0;
          fidx_d   = '0;
          status_d = ST_OK;
          val_d    = DATA_WIDTH'(req_i.word);
          rem_d    = (req_i.req_type == OP_REMOVE);
          state_d  = S_DONE;
          unique case (req_i.req_type) inside
            OP_READ, OP_DELETE: begin
              if (list_empty) begin
                status_d = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                idx_d   = CW'(req_i.position);
                state_d = (req_i.req_type == OP_READ) ? S_RD_ISSUE : S_DN_RD;
              end
            end
            OP_INSERT, OP_PUSH: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else if ((req_i.req_type == OP_INSERT) && (pos_x > cnt_x)) begin
                status_d = ST_RANGE;
              end else begin
                idx_d   = count_q;
                tgt_d   = (req_i.req_type == OP_PUSH) ? count_q : CW'(req_i.position);
                state_d = S_UP_RD;
              end
            end
            OP_POP: begin
              if (list_empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                idx_d   = count_q - CW'(1);
                state_d = S_RD_ISSUE;
              end
            end
            OP_FIND, OP_REMOVE: begin
              if (list_empty) begin
                status_d = ST_NOTFOUND;
              end else begin
                idx_d   = '0;
                state_d = S_SC_RD;
              end
            end
            default: begin
              // The unused code only reports the current fill count.
            end
          endcase
        end
      end
      S_RD_ISSUE: begin
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        rd_d    = WORD_W'(rd_data_q);
        state_d = S_DONE;
      end
      S_UP_RD: begin
        if (idx_q == tgt_q) begin
          // The gap has reached the target slot, so the new word goes in.
          mem_we    = 1'b1;
          mem_waddr = tgt_q[AW-1:0];
          mem_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end else begin
          mem_raddr = idx_step[AW-1:0];
          state_d   = S_UP_WR;
        end
      end
      S_UP_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_UP_RD;
      end
      S_DN_RD: begin
        if (idx_step == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          mem_raddr = idx_step[AW-1:0];
          state_d   = S_DN_WR;
        end
      end
      S_DN_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_DN_RD;
      end
      S_SC_RD: begin
        state_d = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (rd_data_q == val_q) begin
          fidx_d  = FIDX_W'(idx_q);
          state_d = rem_q ? S_DN_RD : S_DONE;
        end else if (idx_step == count_q) begin
          status_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_step;
          state_d = S_SC_RD;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    val_q    <= val_d;
    rem_q    <= rem_d;
    rd_q     <= rd_d;
    fidx_q   <= fidx_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign idle_o            = (state_q == S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign res_o.read_word   = rd_q;
  assign res_o.found_index = fidx_q;
  assign res_o.fill_count  = FILL_W'(count_q);
  assign res_o.empty_res   = (count_q == '0);
  assign res_o.status      = status_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds the list depth");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |=> $stable(count_q))
    else $error("fill count changed with no request in progress");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC_RD) |-> (idx_q < count_q))
    else $error("search walked past the last stored entry");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !take_i) |=> (state_q == S_DONE) && $stable(res_o))
    else $error("finished result changed before it was taken");

endmodule

`default_nettype wire

// ----- design/indexed_list_store_top.sv -----
// Top level of the indexed list store: request channel, result register, list engine.
//
// Requests arrive on in_valid_i / in_ready_o with an in_req_i payload; each one
// gives exactly one result on out_valid_o / out_ready_i with an out_res_o payload.
// The engine walks the list memory one entry at a time through a single
// incrementer and one memory read port, so the time per request follows the
// distance walked: a read or pop does one memory read, an insert or push moves
// each entry at or above the position one slot up, a delete moves each entry
// above it one slot down, a find compares entries from index 0 up to a match
// or the fill count, and a remove finds its value and then deletes it. Each
// moved entry takes a read state and a write state; a failed request or the
// unused code goes straight to its result. The result turns valid in the same
// cycle as the engine turns idle; in_ready_o is high only while the engine is idle.
// Reset empties the list at once; no clearing pass is needed because only
// entries below the fill count are ever read.
// A finished result sits in the output register while the next request is
// accepted and worked on; if the receiver still stalls when that next result
// is ready, the engine holds it and takes no new request until the register
// drains.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store_top import ils_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o
);

  logic eng_idle;
  logic eng_done;
  logic eng_take;
  logic eng_start;
  res_t eng_res;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  assign in_ready_o = eng_idle;
  assign eng_start  = in_valid_i && eng_idle;

  // A result moves to the output register once that register is free or draining.
  assign eng_take = eng_done && (!out_valid_q || out_ready_i);

  ils_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .req_i   (in_req_i),
    .take_i  (eng_take),
    .idle_o  (eng_idle),
    .done_o  (eng_done),
    .res_o   (eng_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_res_q <= eng_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire
